>>> hw/rtl/fall_event_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Fall event detector assertion macros
// Shared assertion wrappers for the fall event detector RTL.
// ----------------------------------------------------------------------------
`ifndef FALL_EVENT_DETECTOR_TOP_DEFINES_SVH
`define FALL_EVENT_DETECTOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FED_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fed: check %m failed");

`define FED_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fed: check %m failed");

`else

`define FED_ASSERT(name, clk, rst_n, prop)

`define FED_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/fed_pkg.sv
// ----------------------------------------------------------------------------
// Fall event detector package
// Types, register indexes, reset values and constants of the detector.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TROUGH_LEVEL  = 3'd0;
  localparam cfg_idx_t REG_IMPACT_LEVEL  = 3'd1;
  localparam cfg_idx_t REG_IMPACT_RATE   = 3'd2;
  localparam cfg_idx_t REG_RECOVER_LEVEL = 3'd3;
  localparam cfg_idx_t REG_RECOVER_RATE  = 3'd4;
  localparam cfg_idx_t REG_POSTURE_COS   = 3'd5;
  localparam cfg_idx_t REG_CANCEL_TIME   = 3'd6;

  localparam logic [31:0]        RST_TROUGH_LEVEL  = 32'd1772093;
  localparam logic [31:0]        RST_IMPACT_LEVEL  = 32'd20300431;
  localparam logic [31:0]        RST_IMPACT_RATE   = 32'd3240000;
  localparam logic [31:0]        RST_RECOVER_LEVEL = 32'd13589545;
  localparam logic [31:0]        RST_RECOVER_RATE  = 32'd1000000;
  localparam logic signed [15:0] RST_POSTURE_COS   = 16'sd23170;
  localparam logic [19:0]        RST_CANCEL_TIME   = 20'd10000;

  typedef struct packed {
    logic [31:0]        trough_level_sq;
    logic [31:0]        impact_level_sq;
    logic [31:0]        impact_rate_sq;
    logic [31:0]        recover_level_sq;
    logic [31:0]        recover_rate_sq;
    logic signed [15:0] posture_cos_limit;
    logic [19:0]        cancel_timeout_ms;
  } cfg_t;

  localparam int unsigned MAC_OP_W   = 33;
  localparam int unsigned MAC_PROD_W = 2 * MAC_OP_W;
  localparam int unsigned MAC_ACC_W  = 97;

  typedef logic signed [MAC_OP_W-1:0]  mac_op_t;
  typedef logic signed [MAC_ACC_W-1:0] mac_acc_t;

  typedef struct packed {
    logic issue;
    logic clr;
    logic sh32;
  } mac_ctl_t;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_IDLE   = 3'd0;
  localparam phase_t PH_TROUGH = 3'd1;
  localparam phase_t PH_IMPACT = 3'd2;
  localparam phase_t PH_WATCH  = 3'd3;
  localparam phase_t PH_COUNT  = 3'd4;

  localparam logic [31:0] ORIENT_MIN_SQ    = 32'd41943;
  localparam logic [31:0] TROUGH_WINDOW_MS = 32'd1000;
  localparam logic [31:0] WATCH_WINDOW_MS  = 32'd1500;
  localparam logic [9:0]  SECONDS_MAX      = 10'd1023;
  localparam logic [20:0] RECIP_1000       = 21'd1073742;
  localparam int unsigned RECIP_SHIFT      = 30;

endpackage

>>> hw/rtl/fed_cfg.sv
// ----------------------------------------------------------------------------
// Fall event detector configuration registers
// Holds the detector thresholds and the countdown length.
// ----------------------------------------------------------------------------
module fed_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  fed_pkg::cfg_idx_t                 wr_index,
  input  logic [fed_pkg::CFG_DATA_W-1:0]    wr_data,
  output fed_pkg::cfg_t                     cfg
);

  fed_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trough_level_sq   <= fed_pkg::RST_TROUGH_LEVEL;
      cfg_r.impact_level_sq   <= fed_pkg::RST_IMPACT_LEVEL;
      cfg_r.impact_rate_sq    <= fed_pkg::RST_IMPACT_RATE;
      cfg_r.recover_level_sq  <= fed_pkg::RST_RECOVER_LEVEL;
      cfg_r.recover_rate_sq   <= fed_pkg::RST_RECOVER_RATE;
      cfg_r.posture_cos_limit <= fed_pkg::RST_POSTURE_COS;
      cfg_r.cancel_timeout_ms <= fed_pkg::RST_CANCEL_TIME;
    end else if (wr_en) begin
      unique case (wr_index)
        fed_pkg::REG_TROUGH_LEVEL:  cfg_r.trough_level_sq   <= wr_data;
        fed_pkg::REG_IMPACT_LEVEL:  cfg_r.impact_level_sq   <= wr_data;
        fed_pkg::REG_IMPACT_RATE:   cfg_r.impact_rate_sq    <= wr_data;
        fed_pkg::REG_RECOVER_LEVEL: cfg_r.recover_level_sq  <= wr_data;
        fed_pkg::REG_RECOVER_RATE:  cfg_r.recover_rate_sq   <= wr_data;
        fed_pkg::REG_POSTURE_COS:   cfg_r.posture_cos_limit <= wr_data[15:0];
        fed_pkg::REG_CANCEL_TIME:   cfg_r.cancel_timeout_ms <= wr_data[19:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/fed_mac.sv
// ----------------------------------------------------------------------------
// Fall event detector multiply-accumulate unit
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module fed_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  fed_pkg::mac_ctl_t ctl,
  input  fed_pkg::mac_op_t  op_a,
  input  fed_pkg::mac_op_t  op_b,
  output fed_pkg::mac_acc_t acc
);

  localparam int unsigned PROD_W = fed_pkg::MAC_PROD_W;
  localparam int unsigned ACC_W  = fed_pkg::MAC_ACC_W;

  fed_pkg::mac_ctl_t        ctl_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  fed_pkg::mac_acc_t        acc_r;
  fed_pkg::mac_acc_t        acc_nxt;
  fed_pkg::mac_acc_t        prod_ext;
  fed_pkg::mac_acc_t        addend;
  fed_pkg::mac_acc_t        base;

  assign prod_nxt = op_a * op_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign addend   = ctl_r.sh32 ? {prod_ext[ACC_W-33:0], 32'b0} : prod_ext;
  assign base     = ctl_r.clr ? '0 : acc_r;
  assign acc_nxt  = base + addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl_r.issue) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

>>> hw/rtl/fall_event_detector_top.sv
// ----------------------------------------------------------------------------
// Fall event detector top level
// Threshold fall detector with posture check and cancel countdown.
// ----------------------------------------------------------------------------
// The input stalls while an item occupies the block: the word is taken, an
// eight-step magnitude pass (or a seventeen-step posture check on the sample
// after an impact) runs, three more steps work out the seconds left while the
// countdown runs, and the result moves into the output register once that
// register is free or being read. Every product goes through the one 33 by 33
// bit multiplier with its accumulator, whose two register stages (product
// and accumulator) set the step counts. A finished word may wait in the
// output register while the next item is taken.
`include "fall_event_detector_top_defines.svh"

module fall_event_detector_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [31:0]                     in_time_ms,
  input  logic signed [15:0]              in_accel_x,
  input  logic signed [15:0]              in_accel_y,
  input  logic signed [15:0]              in_accel_z,
  input  logic signed [15:0]              in_rate_x,
  input  logic signed [15:0]              in_rate_y,
  input  logic signed [15:0]              in_rate_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_fall_confirmed,
  output logic [2:0]                      out_detector_phase,
  output logic [9:0]                      out_seconds_left,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  fed_pkg::cfg_idx_t               cfg_index,
  input  logic [fed_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned OP_W = fed_pkg::MAC_OP_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAG  = 3'd1;
  localparam logic [2:0] ST_POST = 3'd2;
  localparam logic [2:0] ST_SECS = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [4:0] MAG_LAST  = 5'd7;
  localparam logic [4:0] POST_LAST = 5'd16;
  localparam logic [4:0] SECS_LAST = 5'd2;

  fed_pkg::cfg_t     cfg;
  fed_pkg::mac_ctl_t mac_ctl;
  fed_pkg::mac_op_t  mac_a;
  fed_pkg::mac_op_t  mac_b;
  fed_pkg::mac_acc_t acc;

  logic [2:0] st_r;
  logic [2:0] st_nxt;
  logic [4:0] step_r;
  logic [4:0] step_nxt;
  logic       in_acc;

  logic               kind_r;
  logic [31:0]        time_r;
  logic signed [15:0] ax_r;
  logic signed [15:0] ay_r;
  logic signed [15:0] az_r;
  logic signed [15:0] gx_r;
  logic signed [15:0] gy_r;
  logic signed [15:0] gz_r;

  fed_pkg::phase_t    phase_r;
  fed_pkg::phase_t    phase_nxt;
  logic [31:0]        trough_start_r;
  logic [31:0]        trough_start_nxt;
  logic [31:0]        event_start_r;
  logic [31:0]        event_start_nxt;
  logic [31:0]        cd_start_r;
  logic [31:0]        cd_start_nxt;
  logic signed [15:0] pre_r [3];
  logic signed [15:0] pre_nxt [3];
  logic signed [15:0] post_r [3];
  logic signed [15:0] post_nxt [3];
  logic               conf_r;
  logic               conf_nxt;

  logic [31:0]        asq_r;
  logic signed [34:0] dot_r;
  logic [31:0]        p_r;
  logic [31:0]        q_r;
  logic [31:0]        c2_r;
  logic [63:0]        d2_r;
  logic [63:0]        pq_r;
  logic [9:0]         secs_r;

  logic               out_valid_r;
  logic               out_conf_r;
  fed_pkg::phase_t    out_phase_r;
  logic [9:0]         out_secs_r;
  logic               out_load;

  logic [31:0]        gsq;
  logic [31:0]        el_trough;
  logic [31:0]        el_event;
  logic [31:0]        el_cd;
  logic [31:0]        timeout32;
  logic [19:0]        secs_x;
  logic [10:0]        quot;
  logic [9:0]         secs_sat;
  logic [34:0]        dot_abs;
  logic [95:0]        lhs;
  logic [95:0]        rhs;
  logic               posture_chg;
  logic               orient_ok;

  function automatic fed_pkg::mac_op_t sx16(input logic signed [15:0] v);
    return {{(OP_W-16){v[15]}}, v};
  endfunction

  function automatic fed_pkg::mac_op_t zx32(input logic [31:0] v);
    return {{(OP_W-32){1'b0}}, v};
  endfunction

  fed_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fed_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (acc)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign gsq       = acc[31:0];
  assign el_trough = time_r - trough_start_r;
  assign el_event  = time_r - event_start_r;
  assign el_cd     = time_r - cd_start_r;
  assign timeout32 = {12'b0, cfg.cancel_timeout_ms};
  assign secs_x    = (el_cd < timeout32) ? (cfg.cancel_timeout_ms - el_cd[19:0]) : '0;
  assign quot      = acc[fed_pkg::RECIP_SHIFT+10:fed_pkg::RECIP_SHIFT];
  assign secs_sat  = (quot > {1'b0, fed_pkg::SECONDS_MAX}) ? fed_pkg::SECONDS_MAX : quot[9:0];
  assign orient_ok = asq_r > fed_pkg::ORIENT_MIN_SQ;

  // The angle test compares dot^2 * 2^30 with c^2 * P * Q, with the signs
  // of the cosine limit and the dot product handled apart.
  assign dot_abs = dot_r[34] ? 35'(-dot_r) : 35'(dot_r);
  assign lhs     = {2'b0, d2_r, 30'b0};
  assign rhs     = acc[95:0];

  always_comb begin
    if (!cfg.posture_cos_limit[15]) begin
      posture_chg = dot_r[34] || (dot_r == '0) || (lhs <= rhs);
    end else begin
      posture_chg = dot_r[34] && (lhs >= rhs);
    end
  end

  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (st_r)
      ST_MAG: begin
        case (step_r)
          5'd0: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = sx16(ax_r);
            mac_b = sx16(ax_r);
          end
          5'd1: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(ay_r);
            mac_b = sx16(ay_r);
          end
          5'd2: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(az_r);
            mac_b = sx16(az_r);
          end
          5'd3: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = sx16(gx_r);
            mac_b = sx16(gx_r);
          end
          5'd4: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(gy_r);
            mac_b = sx16(gy_r);
          end
          5'd5: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(gz_r);
            mac_b = sx16(gz_r);
          end
          default: begin
          end
        endcase
      end
      ST_POST: begin
        case (step_r)
          5'd0: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = sx16(pre_r[0]);
            mac_b = sx16(post_r[0]);
          end
          5'd1: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(pre_r[1]);
            mac_b = sx16(post_r[1]);
          end
          5'd2: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(pre_r[2]);
            mac_b = sx16(post_r[2]);
          end
          5'd3: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = sx16(pre_r[0]);
            mac_b = sx16(pre_r[0]);
          end
          5'd4: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(pre_r[1]);
            mac_b = sx16(pre_r[1]);
          end
          5'd5: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(pre_r[2]);
            mac_b = sx16(pre_r[2]);
          end
          5'd6: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = sx16(post_r[0]);
            mac_b = sx16(post_r[0]);
          end
          5'd7: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(post_r[1]);
            mac_b = sx16(post_r[1]);
          end
          5'd8: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b0};
            mac_a = sx16(post_r[2]);
            mac_b = sx16(post_r[2]);
          end
          5'd9: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = sx16(cfg.posture_cos_limit);
            mac_b = sx16(cfg.posture_cos_limit);
          end
          5'd10: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = zx32(dot_abs[31:0]);
            mac_b = zx32(dot_abs[31:0]);
          end
          5'd11: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = zx32(p_r);
            mac_b = zx32(q_r);
          end
          5'd13: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
            mac_a = zx32(c2_r);
            mac_b = zx32(acc[31:0]);
          end
          5'd14: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh32: 1'b1};
            mac_a = zx32(c2_r);
            mac_b = zx32(pq_r[63:32]);
          end
          default: begin
          end
        endcase
      end
      ST_SECS: begin
        if (step_r == 5'd0) begin
          mac_ctl = '{issue: 1'b1, clr: 1'b1, sh32: 1'b0};
          mac_a = zx32({12'b0, secs_x});
          mac_b = zx32({11'b0, fed_pkg::RECIP_1000});
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt           = st_r;
    step_nxt         = step_r + 5'd1;
    phase_nxt        = phase_r;
    trough_start_nxt = trough_start_r;
    event_start_nxt  = event_start_r;
    cd_start_nxt     = cd_start_r;
    pre_nxt          = pre_r;
    post_nxt         = post_r;
    conf_nxt         = conf_r;
    unique case (st_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_acc) begin
          conf_nxt = 1'b0;
          st_nxt   = (!in_kind && phase_r == fed_pkg::PH_IMPACT) ? ST_POST : ST_MAG;
        end
      end
      ST_MAG: begin
        if (step_r == MAG_LAST) begin
          step_nxt = '0;
          if (kind_r) begin
            if (phase_r == fed_pkg::PH_COUNT) begin
              phase_nxt = fed_pkg::PH_IDLE;
            end
          end else begin
            unique case (phase_r)
              fed_pkg::PH_IDLE: begin
                if (asq_r < cfg.trough_level_sq) begin
                  phase_nxt        = fed_pkg::PH_TROUGH;
                  trough_start_nxt = time_r;
                  if (orient_ok) begin
                    pre_nxt = '{ax_r, ay_r, az_r};
                  end
                end
              end
              fed_pkg::PH_TROUGH: begin
                if (el_trough > fed_pkg::TROUGH_WINDOW_MS) begin
                  phase_nxt = fed_pkg::PH_IDLE;
                end else if (asq_r > cfg.impact_level_sq || gsq > cfg.impact_rate_sq) begin
                  phase_nxt       = fed_pkg::PH_IMPACT;
                  event_start_nxt = time_r;
                  if (orient_ok) begin
                    post_nxt = '{ax_r, ay_r, az_r};
                  end
                end
              end
              fed_pkg::PH_WATCH: begin
                if (el_event < fed_pkg::WATCH_WINDOW_MS) begin
                  if (asq_r > cfg.recover_level_sq || gsq > cfg.recover_rate_sq) begin
                    phase_nxt = fed_pkg::PH_IDLE;
                  end
                end else begin
                  phase_nxt    = fed_pkg::PH_COUNT;
                  cd_start_nxt = time_r;
                end
              end
              fed_pkg::PH_COUNT: begin
                if (el_cd >= timeout32) begin
                  phase_nxt = fed_pkg::PH_IDLE;
                  conf_nxt  = 1'b1;
                end
              end
              default: begin
                phase_nxt = fed_pkg::PH_IDLE;
              end
            endcase
          end
          st_nxt = (phase_nxt == fed_pkg::PH_COUNT) ? ST_SECS : ST_OUT;
        end
      end
      ST_POST: begin
        if (step_r == POST_LAST) begin
          step_nxt = '0;
          st_nxt   = ST_OUT;
          if (posture_chg) begin
            phase_nxt       = fed_pkg::PH_WATCH;
            event_start_nxt = time_r;
          end else begin
            phase_nxt = fed_pkg::PH_IDLE;
          end
        end
      end
      ST_SECS: begin
        if (step_r == SECS_LAST) begin
          step_nxt = '0;
          st_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        step_nxt = '0;
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        step_nxt = '0;
        st_nxt   = ST_IDLE;
      end
    endcase
  end

  assign out_load = (st_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      step_r         <= '0;
      phase_r        <= fed_pkg::PH_IDLE;
      trough_start_r <= '0;
      event_start_r  <= '0;
      cd_start_r     <= '0;
      pre_r          <= '{16'sd0, 16'sd0, 16'sd2048};
      post_r         <= '{16'sd0, 16'sd0, 16'sd2048};
      conf_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      st_r           <= st_nxt;
      step_r         <= step_nxt;
      phase_r        <= phase_nxt;
      trough_start_r <= trough_start_nxt;
      event_start_r  <= event_start_nxt;
      cd_start_r     <= cd_start_nxt;
      pre_r          <= pre_nxt;
      post_r         <= post_nxt;
      conf_r         <= conf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      time_r <= in_time_ms;
      ax_r   <= in_accel_x;
      ay_r   <= in_accel_y;
      az_r   <= in_accel_z;
      gx_r   <= in_rate_x;
      gy_r   <= in_rate_y;
      gz_r   <= in_rate_z;
    end
    if (st_r == ST_MAG && step_r == 5'd4) begin
      asq_r <= acc[31:0];
    end
    if (st_r == ST_POST) begin
      case (step_r)
        5'd4:  dot_r <= acc[34:0];
        5'd7:  p_r   <= acc[31:0];
        5'd10: q_r   <= acc[31:0];
        5'd11: c2_r  <= acc[31:0];
        5'd12: d2_r  <= acc[63:0];
        5'd13: pq_r  <= acc[63:0];
        default: begin
        end
      endcase
    end
    if (st_r == ST_SECS && step_r == SECS_LAST) begin
      secs_r <= secs_sat;
    end else if ((st_r == ST_MAG && step_r == MAG_LAST) ||
                 (st_r == ST_POST && step_r == POST_LAST)) begin
      secs_r <= '0;
    end
    if (out_load) begin
      out_conf_r  <= conf_r;
      out_phase_r <= phase_r;
      out_secs_r  <= secs_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fall_confirmed = out_conf_r;
  assign out_detector_phase = out_phase_r;
  assign out_seconds_left   = out_secs_r;

  `FED_ASSERT_IMPL(a_conf_idle, clk, rst_n, out_valid_r && out_conf_r, out_phase_r == fed_pkg::PH_IDLE)
  `FED_ASSERT_IMPL(a_secs_count, clk, rst_n, out_valid_r && (out_secs_r != '0), out_phase_r == fed_pkg::PH_COUNT)
  `FED_ASSERT_IMPL(a_secs_phase, clk, rst_n, st_r == ST_SECS, phase_r == fed_pkg::PH_COUNT)
  `FED_ASSERT(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(st_r == ST_OUT))
  `FED_ASSERT_IMPL(a_post_from_impact, clk, rst_n, (st_r == ST_POST) && (step_r == 5'd0), phase_r == fed_pkg::PH_IMPACT)

endmodule
